### src/slcpa_pkg.sv
package slcpa_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] FLG_CONTINUE = 4'h1;
  localparam logic [3:0] FLG_CURRENT  = 4'h2;
  localparam logic [3:0] FLG_PARENT   = 4'h4;
  localparam logic [3:0] FLG_ROOT     = 4'h8;

  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'b001,
    PH_LEN   = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] path_char;
    logic       path_end;
    logic       malformed;
  } res_t;

  typedef struct packed {
    logic [1:0]                cnt;
    res_t [MAX_RES-1:0]        item;
  } push_t;

endpackage

### src/slcpa_decode.sv
module slcpa_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          comp_byte,
  input  logic                area_end,
  output slcpa_pkg::push_t    push
);

  slcpa_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        flags_r, flags_nxt;
  logic [7:0]        left_r, left_nxt;

  logic [1:0]        n;
  logic [7:0]        left_dec;
  logic              do_finish;
  logic              do_bad;
  slcpa_pkg::res_t [slcpa_pkg::MAX_RES-1:0] item;

  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    left_nxt  = left_r;
    n         = 2'd0;
    item      = '0;
    do_finish = 1'b0;
    do_bad    = 1'b0;
    left_dec  = left_r - 8'd1;
    if (acc) begin
      unique case (phase_r)
        slcpa_pkg::PH_LEN: begin
          if ((comp_byte != 8'd0) && area_end) begin
            do_bad = 1'b1;
          end else begin
            if ((flags_r & slcpa_pkg::FLG_ROOT) != 4'd0) begin
              n = 2'd0;
            end else if ((flags_r & slcpa_pkg::FLG_CURRENT) != 4'd0) begin
              item[0] = '{path_char: slcpa_pkg::CH_DOT, path_end: 1'b0, malformed: 1'b0};
              n = 2'd1;
            end else if ((flags_r & slcpa_pkg::FLG_PARENT) != 4'd0) begin
              item[0] = '{path_char: slcpa_pkg::CH_DOT, path_end: 1'b0, malformed: 1'b0};
              item[1] = '{path_char: slcpa_pkg::CH_DOT, path_end: 1'b0, malformed: 1'b0};
              n = 2'd2;
            end
            if (comp_byte == 8'd0) begin
              do_finish = 1'b1;
            end else begin
              left_nxt  = comp_byte;
              phase_nxt = slcpa_pkg::PH_DATA;
            end
          end
        end
        slcpa_pkg::PH_DATA: begin
          if ((flags_r & (slcpa_pkg::FLG_ROOT | slcpa_pkg::FLG_CURRENT |
                          slcpa_pkg::FLG_PARENT)) == 4'd0) begin
            item[0] = '{path_char: comp_byte, path_end: 1'b0, malformed: 1'b0};
            n = 2'd1;
          end
          left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            do_finish = 1'b1;
          end else if (area_end) begin
            do_bad = 1'b1;
          end
        end
        default: begin
          flags_nxt = comp_byte[3:0];
          left_nxt  = 8'd0;
          if (area_end) begin
            do_bad = 1'b1;
          end else begin
            phase_nxt = slcpa_pkg::PH_LEN;
          end
        end
      endcase

      if (do_bad) begin
        item[n] = '{path_char: slcpa_pkg::CH_NUL, path_end: 1'b1, malformed: 1'b1};
        n = n + 2'd1;
      end else if (do_finish) begin
        if (area_end) begin
          item[n] = '{path_char: slcpa_pkg::CH_NUL, path_end: 1'b1, malformed: 1'b0};
          n = n + 2'd1;
        end else if ((flags_r & slcpa_pkg::FLG_CONTINUE) == 4'd0) begin
          item[n] = '{path_char: slcpa_pkg::CH_SLASH, path_end: 1'b0, malformed: 1'b0};
          n = n + 2'd1;
        end
      end
      if (do_bad || do_finish) begin
        phase_nxt = slcpa_pkg::PH_FLAGS;
        flags_nxt = 4'd0;
        left_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slcpa_pkg::PH_FLAGS;
      flags_r <= 4'd0;
      left_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      left_r  <= left_nxt;
    end
  end

  assign push.cnt  = n;
  assign push.item = item;

  // data phase always has bytes outstanding
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == slcpa_pkg::PH_DATA |-> left_r != 8'd0)
    else $error("data phase with zero bytes left");

  // a malformed mark only rides on a terminator
  a_bad_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!item[0].malformed || item[0].path_end) && (!item[1].malformed || item[1].path_end) &&
    (!item[2].malformed || item[2].path_end))
    else $error("malformed without path_end");

  // a terminator returns the parser to its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (item[0].path_end || item[1].path_end || item[2].path_end)
    |=> phase_r == slcpa_pkg::PH_FLAGS && flags_r == 4'd0 && left_r == 8'd0)
    else $error("state not cleared after terminator");

endmodule

### src/slcpa_rbuf.sv
module slcpa_rbuf #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  slcpa_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output slcpa_pkg::res_t  out_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  slcpa_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wp [slcpa_pkg::MAX_RES+1];
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wp[0] = wr_ptr_r;
    for (int i = 1; i <= slcpa_pkg::MAX_RES; i++) begin
      wp[i] = ptr_inc(wp[i-1]);
    end
  end

  assign pop        = out_valid && !out_stall;
  assign out_valid  = count_r != '0;
  assign out_item   = mem_r[rd_ptr_r];
  assign room       = count_r <= CW'(DEPTH - slcpa_pkg::MAX_RES);
  assign rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  assign count_nxt  = count_r + CW'(push.cnt) - CW'(pop);

  always_comb begin
    unique case (push.cnt)
      2'd1:    wr_ptr_nxt = wp[1];
      2'd2:    wr_ptr_nxt = wp[2];
      2'd3:    wr_ptr_nxt = wp[3];
      default: wr_ptr_nxt = wp[0];
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < slcpa_pkg::MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wp[i]] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> (count_r + CW'(push.cnt)) <= CW'(DEPTH))
    else $error("result buffer overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_r) + CW'($past(push.cnt)) - CW'($past(pop)))
    else $error("result count mismatch");

endmodule

### src/symlink_component_path_assembler.sv
// Rock Ridge symlink component decoder.
// Input channel (in_valid / in_stall): one byte of the SL component area per
// request, in_area_end high on the final byte of the area.
// Output channel (out_valid / out_stall): one path character per request;
// the path closes with a NUL carrying out_path_end, and out_malformed is set
// on that NUL when the area stopped inside a component.
// Results of a byte are registered when it is accepted and, in an empty buffer,
// show the cycle after; they leave in order, one per cycle unless stalled.
// Throughput: one input byte per cycle while the result buffer holds no more
// than RBUF_DEPTH-3 entries; one byte makes up to three results, so a run of
// such bytes is paced by the single-result output port.
// When the receiver stalls, results collect in the RBUF_DEPTH-entry buffer
// and in_stall rises once fewer than three slots are free.
// Reset clears the parser to expect a flags byte and empties the buffer.
// After every terminator the parser also returns to that state.
module symlink_component_path_assembler #(
  parameter int RBUF_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_comp_byte,
  input  logic       in_area_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_path_char,
  output logic       out_path_end,
  output logic       out_malformed
);

  slcpa_pkg::push_t push;
  slcpa_pkg::res_t  out_item;
  logic             room;
  logic             acc;

  assign in_stall = !room;
  assign acc      = in_valid && room;

  slcpa_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .comp_byte (in_comp_byte),
    .area_end  (in_area_end),
    .push      (push)
  );

  slcpa_rbuf #(
    .DEPTH (RBUF_DEPTH)
  ) u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_path_char = out_item.path_char;
  assign out_path_end  = out_item.path_end;
  assign out_malformed = out_item.malformed;

endmodule
